// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

// Consequent must hold in the same cycle as the antecedent, outside reset
`define CHK_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle check that also runs during reset
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: reset check");

`endif

// ===== rtl/sbl_pkg.sv =====
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared types and constants of the RGB Sobel edge detector.
// ----------------------------------------------------------------------------
`default_nettype none

package sbl_pkg;

  localparam int PIX_W          = 8;
  localparam int RGB_W          = 3 * PIX_W;
  localparam int LANES          = 3;
  localparam int FW_W           = 11;
  localparam int FH_W           = 13;
  localparam int CFG_W          = 13;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int GRAD_W         = 12;
  localparam int SUM_W          = 21;

  localparam logic [FW_W-1:0]  FW_RESET  = 11'd640;
  localparam logic [FH_W-1:0]  FH_RESET  = 13'd480;
  localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65280;
  localparam logic [PIX_W-1:0] MAG_MAX   = 8'd255;

  // Register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // Lane control from the sequencer
  typedef struct packed {
    logic       grad;
    logic       square;
    logic       step;
    logic [2:0] bit_idx;
  } sbl_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sbl_line_buf.sv =====
// ----------------------------------------------------------------------------
// sbl_line_buf
// Two line stores indexed by column, registered read, one write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_line_buf #(
  parameter int MAX_WIDTH = sbl_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
  input  wire logic [sbl_pkg::RGB_W-1:0]       wr_top,
  input  wire logic [sbl_pkg::RGB_W-1:0]       wr_mid,
  output logic      [sbl_pkg::RGB_W-1:0]       rd_top,
  output logic      [sbl_pkg::RGB_W-1:0]       rd_mid
);

  logic [sbl_pkg::RGB_W-1:0] top_mem [MAX_WIDTH];
  logic [sbl_pkg::RGB_W-1:0] mid_mem [MAX_WIDTH];

  // Read both rows, write the shifted column
  always_ff @(posedge clk) begin
    rd_top <= top_mem[rd_addr];
    rd_mid <= mid_mem[rd_addr];
    if (wr_en) begin
      top_mem[wr_addr] <= wr_top;
      mid_mem[wr_addr] <= wr_mid;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sbl_lane.sv =====
// ----------------------------------------------------------------------------
// sbl_lane
// One color channel: Sobel gradients, squared magnitude, bitwise square root.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_lane (
  input  wire logic                          clk,
  input  wire sbl_pkg::sbl_ctrl_t            ctrl,
  input  wire logic [sbl_pkg::PIX_W-1:0]     px [9],
  output logic      [sbl_pkg::PIX_W-1:0]     mag
);

  logic signed [sbl_pkg::GRAD_W-1:0]   gx_r, gy_r;
  logic signed [sbl_pkg::GRAD_W-1:0]   gx, gy;
  logic signed [2*sbl_pkg::GRAD_W-1:0] sqx, sqy;
  logic [sbl_pkg::SUM_W-1:0]           sum_r;
  logic                                big_r;
  logic [sbl_pkg::PIX_W-1:0]           n_r;
  logic [sbl_pkg::PIX_W-1:0]           trial;
  logic [2*sbl_pkg::PIX_W-1:0]         trial_sq;
  logic [2*sbl_pkg::PIX_W-1:0]         n_sq;
  logic [2*sbl_pkg::PIX_W:0]           n_edge;
  logic [sbl_pkg::PIX_W:0]             n_rnd;

  function automatic logic signed [sbl_pkg::GRAD_W-1:0] ext(
    input logic [sbl_pkg::PIX_W-1:0] v
  );
    return $signed({{(sbl_pkg::GRAD_W-sbl_pkg::PIX_W){1'b0}}, v});
  endfunction

  // Kernel sums over the masked window
  always_comb begin
    gx = (ext(px[2]) - ext(px[0])) + ((ext(px[5]) - ext(px[3])) <<< 1)
       + (ext(px[8]) - ext(px[6]));
    gy = (ext(px[6]) + (ext(px[7]) <<< 1) + ext(px[8]))
       - (ext(px[0]) + (ext(px[1]) <<< 1) + ext(px[2]));
  end

  assign sqx      = gx_r * gx_r;
  assign sqy      = gy_r * gy_r;
  assign trial    = n_r | (sbl_pkg::PIX_W'(1) << ctrl.bit_idx);
  assign trial_sq = trial * trial;
  assign n_sq     = n_r * n_r;
  assign n_edge   = (2*sbl_pkg::PIX_W+1)'(n_sq) + (2*sbl_pkg::PIX_W+1)'(n_r);

  // Round to nearest and clamp
  always_comb begin
    if (sum_r > sbl_pkg::SUM_W'(n_edge)) n_rnd = (sbl_pkg::PIX_W+1)'(n_r) + 1'b1;
    else n_rnd = (sbl_pkg::PIX_W+1)'(n_r);
    if (big_r || n_rnd[sbl_pkg::PIX_W]) mag = sbl_pkg::MAG_MAX;
    else mag = n_rnd[sbl_pkg::PIX_W-1:0];
  end

  // Gradient, square and root steps
  always_ff @(posedge clk) begin
    if (ctrl.grad) begin
      gx_r <= gx;
      gy_r <= gy;
    end
    if (ctrl.square) begin
      sum_r <= sbl_pkg::SUM_W'(unsigned'(sqx)) + sbl_pkg::SUM_W'(unsigned'(sqy));
      big_r <= (sbl_pkg::SUM_W'(unsigned'(sqx)) + sbl_pkg::SUM_W'(unsigned'(sqy)))
               > sbl_pkg::SAT_LIMIT;
      n_r   <= '0;
    end
    if (ctrl.step && (sbl_pkg::SUM_W'(trial_sq) <= sum_r)) begin
      n_r <= trial;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sobel_edge_rgb.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_rgb
// 3x3 Sobel edge magnitude on RGB raster pixels, one lane per channel.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// in        in_valid / in_stall    in_blue, in_green, in_red, in_flush
// out       out_valid / out_stall  out_edge_blue/green/red, out_frame_end
// cfg       cfg_wr_en              cfg_index, cfg_wdata
//
// An item that yields a result passes these steps from accept to out_valid:
// line store read, window shift, gradient, square, 8 root iterations of
// the channel lanes, merge. The next item is taken only after out_valid
// falls, which out_stall holds off; an item without a result passes the
// window shift only, and an ignored flush is dropped while idle.
// Reset clears counters and window and sets the frame size to 640 x 480;
// the line stores are not cleared, stale entries are masked by position.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_rgb #(
  parameter int MAX_WIDTH  = sbl_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sbl_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [sbl_pkg::PIX_W-1:0]   in_blue,
  input  wire logic [sbl_pkg::PIX_W-1:0]   in_green,
  input  wire logic [sbl_pkg::PIX_W-1:0]   in_red,
  input  wire logic                        in_flush,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [sbl_pkg::PIX_W-1:0]   out_edge_blue,
  output logic      [sbl_pkg::PIX_W-1:0]   out_edge_green,
  output logic      [sbl_pkg::PIX_W-1:0]   out_edge_red,
  output logic                             out_frame_end,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_index,
  input  wire logic [sbl_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SHIFT, ST_GRAD, ST_SQ, ST_ROOT, ST_MERGE, ST_OUT
  } state_t;

  state_t                       state_r;
  logic [sbl_pkg::FW_W-1:0]     fw_r;
  logic [sbl_pkg::FH_W-1:0]     fh_r;
  logic [AW-1:0]                in_col_r;
  logic [HW-1:0]                in_row_r;
  logic [AW-1:0]                out_col_r;
  logic [RW-1:0]                out_row_r;
  logic [2:0]                   bit_r;
  logic [sbl_pkg::RGB_W-1:0]    pix_r;
  logic [sbl_pkg::RGB_W-1:0]    win_r [9];
  logic [sbl_pkg::PIX_W-1:0]    edge_r [sbl_pkg::LANES];
  logic                         frame_end_r;
  logic                         out_valid_r;

  logic [WW-1:0]                used_w;
  logic [HW-1:0]                used_h;
  logic                         in_frame;
  logic                         emit;
  logic [WW-1:0]                in_col_inc;
  logic [WW-1:0]                out_col_inc;
  logic [HW-1:0]                out_row_inc;
  logic [2:0]                   row_ok, col_ok;
  logic [sbl_pkg::RGB_W-1:0]    rd_top, rd_mid;
  logic [sbl_pkg::PIX_W-1:0]    mag [sbl_pkg::LANES];
  sbl_pkg::sbl_ctrl_t           ctrl;

  // Clamp the frame size registers to the supported range
  always_comb begin
    if (fw_r == '0) used_w = WW'(1);
    else if (32'(fw_r) > 32'(MAX_WIDTH)) used_w = WW'(MAX_WIDTH);
    else used_w = WW'(fw_r);
    if (fh_r == '0) used_h = HW'(1);
    else if (32'(fh_r) > 32'(MAX_HEIGHT)) used_h = HW'(MAX_HEIGHT);
    else used_h = HW'(fh_r);
  end

  assign in_frame    = in_row_r < used_h;
  assign emit        = (in_row_r > HW'(1)) || ((in_row_r == HW'(1)) && (in_col_r != '0));
  assign in_col_inc  = WW'(in_col_r) + WW'(1);
  assign out_col_inc = WW'(out_col_r) + WW'(1);
  assign out_row_inc = HW'(out_row_r) + HW'(1);

  // Mask window rows and columns that fall outside the frame
  always_comb begin
    row_ok = {out_row_inc < used_h, 1'b1, out_row_r != '0};
    col_ok = {out_col_inc < used_w, 1'b1, out_col_r != '0};
  end

  sbl_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_addr (in_col_r),
    .wr_en   (state_r == ST_SHIFT),
    .wr_addr (in_col_r),
    .wr_top  (rd_mid),
    .wr_mid  (pix_r),
    .rd_top  (rd_top),
    .rd_mid  (rd_mid)
  );

  always_comb begin
    ctrl.grad    = (state_r == ST_GRAD);
    ctrl.square  = (state_r == ST_SQ);
    ctrl.step    = (state_r == ST_ROOT);
    ctrl.bit_idx = bit_r;
  end

  // One lane per color channel
  for (genvar l = 0; l < sbl_pkg::LANES; l++) begin : g_lane
    logic [sbl_pkg::PIX_W-1:0] px [9];
    for (genvar k = 0; k < 9; k++) begin : g_tap
      assign px[k] = (row_ok[k/3] && col_ok[k%3]) ?
                     win_r[k][l*sbl_pkg::PIX_W +: sbl_pkg::PIX_W] : '0;
    end
    sbl_lane u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .px   (px),
      .mag  (mag[l])
    );
  end

  // Sequencer, counters, window and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fw_r        <= sbl_pkg::FW_RESET;
      fh_r        <= sbl_pkg::FH_RESET;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          // drop a flush inside the frame
          if (in_valid && !(in_frame && in_flush)) begin
            pix_r   <= in_frame ? {in_red, in_green, in_blue} : '0;
            state_r <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          for (int d = 0; d < 3; d++) begin
            win_r[d*3]   <= win_r[d*3+1];
            win_r[d*3+1] <= win_r[d*3+2];
          end
          win_r[2] <= rd_top;
          win_r[5] <= rd_mid;
          win_r[8] <= pix_r;
          if (in_col_inc >= used_w) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + HW'(1);
          end else begin
            in_col_r <= in_col_r + AW'(1);
          end
          state_r <= emit ? ST_GRAD : ST_IDLE;
        end
        ST_GRAD: begin
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          bit_r   <= 3'd7;
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          bit_r <= bit_r - 3'd1;
          if (bit_r == 3'd0) state_r <= ST_MERGE;
        end
        ST_MERGE: begin
          for (int l = 0; l < sbl_pkg::LANES; l++) edge_r[l] <= mag[l];
          frame_end_r <= 1'b0;
          out_valid_r <= 1'b1;
          state_r     <= ST_OUT;
          if (out_col_inc >= used_w) begin
            out_col_r <= '0;
            if (out_row_inc >= used_h) begin
              // end of frame: restart all positions
              frame_end_r <= 1'b1;
              out_row_r   <= '0;
              in_col_r    <= '0;
              in_row_r    <= '0;
              for (int i = 0; i < 9; i++) win_r[i] <= '0;
            end else begin
              out_row_r <= out_row_r + RW'(1);
            end
          end else begin
            out_col_r <= out_col_r + AW'(1);
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // configuration write restarts the frame
      if (cfg_wr_en) begin
        case (cfg_index)
          sbl_pkg::CFG_FRAME_WIDTH:  fw_r <= cfg_wdata[sbl_pkg::FW_W-1:0];
          sbl_pkg::CFG_FRAME_HEIGHT: fh_r <= cfg_wdata[sbl_pkg::FH_W-1:0];
          default: fw_r <= fw_r;
        endcase
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        for (int i = 0; i < 9; i++) win_r[i] <= '0;
      end
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_edge_blue  = edge_r[0];
  assign out_edge_green = edge_r[1];
  assign out_edge_red   = edge_r[2];
  assign out_frame_end  = frame_end_r;

endmodule

`default_nettype wire

// ===== rtl/sbl_checker.sv =====
// ----------------------------------------------------------------------------
// sbl_checker
// Port-level checks of the Sobel edge detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sbl_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [sbl_pkg::PIX_W-1:0]  out_edge_blue,
  input wire logic [sbl_pkg::PIX_W-1:0]  out_edge_green,
  input wire logic [sbl_pkg::PIX_W-1:0]  out_edge_red,
  input wire logic                       out_frame_end
);

  // Stalled result keeps valid and payload
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `CHK_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_edge_blue) && $stable(out_edge_green) && $stable(out_edge_red) && $stable(out_frame_end))

  // No new item taken while a result waits
  `CHK_NOW(a_busy_out, clk, rst_n, out_valid, in_stall)

  // One result per item: a taken result is not shown again
  `CHK_NEXT(a_out_once, clk, rst_n, out_valid && !out_stall, !out_valid)

  // Reset clears the result
  `CHK_NEXT_ALWAYS(a_rst_clear, clk, !rst_n, !out_valid)

endmodule

bind sobel_edge_rgb sbl_checker u_sbl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_edge_blue  (out_edge_blue),
  .out_edge_green (out_edge_green),
  .out_edge_red   (out_edge_red),
  .out_frame_end  (out_frame_end)
);

`default_nettype wire

// ===== test/sobel_edge_rgb_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_rgb_chk
// Watches the input, output and configuration channels of the RGB Sobel detector, predicts each edge
// pixel from its own window and line stores, and compares in order.
// ----------------------------------------------------------------------------
module sobel_edge_rgb_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [sbl_pkg::PIX_W-1:0]     in_blue,
  input  logic [sbl_pkg::PIX_W-1:0]     in_green,
  input  logic [sbl_pkg::PIX_W-1:0]     in_red,
  input  logic                          in_flush,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [sbl_pkg::PIX_W-1:0]     out_edge_blue,
  input  logic [sbl_pkg::PIX_W-1:0]     out_edge_green,
  input  logic [sbl_pkg::PIX_W-1:0]     out_edge_red,
  input  logic                          out_frame_end,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [sbl_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending_edges,
  output int                            edge_count
);

  localparam int MW = sbl_pkg::MAX_WIDTH_DEF;
  localparam int MH = sbl_pkg::MAX_HEIGHT_DEF;

  typedef struct packed {
    logic [sbl_pkg::PIX_W-1:0] b;
    logic [sbl_pkg::PIX_W-1:0] g;
    logic [sbl_pkg::PIX_W-1:0] r;
    logic                      fend;
  } edge_px_t;

  logic [sbl_pkg::FW_W-1:0]  fw_reg;
  logic [sbl_pkg::FH_W-1:0]  fh_reg;
  logic [sbl_pkg::RGB_W-1:0] lines [0:2*MW-1];
  logic [sbl_pkg::RGB_W-1:0] win [0:8];
  int                        icol, irow, ocol, orow;
  edge_px_t                  edge_q [$];

  function automatic int eff_w();
    if (fw_reg == 0) return 1;
    return (fw_reg > MW) ? MW : int'(fw_reg);
  endfunction

  function automatic int eff_h();
    if (fh_reg == 0) return 1;
    return (fh_reg > MH) ? MH : int'(fh_reg);
  endfunction

  // Round-to-nearest integer square root, saturated to 255
  function automatic logic [7:0] root_mag(int unsigned s);
    int unsigned n;
    if (s > 65280) return 8'd255;
    n = 0;
    while ((n + 1) * (n + 1) <= s) n++;
    if (s > n * n + n) n++;
    return (n > 255) ? 8'd255 : n[7:0];
  endfunction

  task automatic frame_restart();
    for (int k = 0; k < 9; k++) win[k] = '0;
    icol = 0; irow = 0; ocol = 0; orow = 0;
  endtask

  // Advance the window for one accepted item and queue its edge pixel
  task automatic take_item(logic [sbl_pkg::RGB_W-1:0] px_in, logic fl);
    int w, h, c, gx, gy, rr, cc, v;
    logic [sbl_pkg::RGB_W-1:0] px, top, mid;
    logic emit;
    edge_px_t e;
    logic [7:0] m [0:2];
    w = eff_w(); h = eff_h();
    if (irow < h && fl) return;
    px = (irow < h) ? px_in : '0;
    c = icol % MW;
    top = lines[MW + c];
    mid = lines[c];
    lines[MW + c] = mid;
    lines[c] = px;
    for (int d = 0; d < 3; d++) begin
      win[d*3] = win[d*3+1];
      win[d*3+1] = win[d*3+2];
    end
    win[2] = top; win[5] = mid; win[8] = px;
    emit = (irow > 1) || (irow == 1 && icol >= 1);
    icol++;
    if (icol >= w) begin
      icol = 0;
      irow++;
    end
    if (!emit) return;
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0; gy = 0;
      for (int dr = 0; dr < 3; dr++) begin
        rr = orow + dr - 1;
        if (rr < 0 || rr >= h) continue;
        for (int dc = 0; dc < 3; dc++) begin
          cc = ocol + dc - 1;
          if (cc < 0 || cc >= w) continue;
          v = (win[dr*3+dc] >> (8*ch)) & 8'hFF;
          gx += v * (dc - 1) * ((dr == 1) ? 2 : 1);
          gy += v * (dr - 1) * ((dc == 1) ? 2 : 1);
        end
      end
      m[ch] = root_mag(gx * gx + gy * gy);
    end
    e.b = m[0]; e.g = m[1]; e.r = m[2]; e.fend = 1'b0;
    ocol++;
    if (ocol >= w) begin
      ocol = 0;
      orow++;
      if (orow >= h) begin
        e.fend = 1'b1;
        frame_restart();
      end
    end
    edge_q.push_back(e);
  endtask

  task automatic note_miss(string what, edge_px_t exp_v, edge_px_t got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch %s: exp b=%0d g=%0d r=%0d end=%0b",
               $realtime, what, exp_v.b, exp_v.g, exp_v.r, exp_v.fend,
               " got b=%0d g=%0d r=%0d end=%0b",
               got_v.b, got_v.g, got_v.r, got_v.fend);
  endtask

  // Track config, inputs and outputs at each rising edge
  always @(posedge clk) begin
    edge_px_t got, want;
    if (!rst_n) begin
      fw_reg = sbl_pkg::FW_RESET;
      fh_reg = sbl_pkg::FH_RESET;
      frame_restart();
      edge_q.delete();
      fail_count = 0;
      edge_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_edge_blue, out_edge_green, out_edge_red, out_frame_end};
        edge_count++;
        if (edge_q.size() == 0) begin
          note_miss("unexpected item", '0, got);
        end else begin
          want = edge_q.pop_front();
          if (got !== want) note_miss("field", want, got);
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == sbl_pkg::CFG_FRAME_WIDTH) fw_reg = cfg_wdata[sbl_pkg::FW_W-1:0];
        else fh_reg = cfg_wdata[sbl_pkg::FH_W-1:0];
        frame_restart();
      end else if (in_valid && !in_stall) begin
        take_item({in_red, in_green, in_blue}, in_flush);
      end
    end
    pending_edges = edge_q.size();
  end
endmodule

// ===== test/sobel_edge_rgb_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_rgb_tb
// Drives frames of several sizes through the RGB Sobel detector with random
// pixels, flushes and stalls; the checker compares every edge pixel.
// ----------------------------------------------------------------------------
module sobel_edge_rgb_tb;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [sbl_pkg::PIX_W-1:0] in_blue = '0, in_green = '0, in_red = '0;
  logic                      in_flush = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [sbl_pkg::PIX_W-1:0] out_edge_blue, out_edge_green, out_edge_red;
  logic                      out_frame_end;
  logic                      cfg_wr_en = 1'b0;
  logic                      cfg_index = sbl_pkg::CFG_FRAME_WIDTH;
  logic [sbl_pkg::CFG_W-1:0] cfg_wdata = '0;
  int                        fail_count, pending_edges, edge_count;
  int                        pixels_sent = 0, items_sent = 0, frames_run = 0;
  bit                        calm = 1'b0;
  bit                        hold_out = 1'b0;

  always #4 clk = ~clk;

  sobel_edge_rgb dut (.*);
  sobel_edge_rgb_chk chk (.*);

  // Receiver stall: random bursts, or a long hold when asked
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_out) out_stall <= 1'b1;
      else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 11);
        repeat (n - 1) @(negedge clk);
      end else out_stall <= 1'b0;
    end
  end

  // Offer one item and hold it until accepted, with an optional idle burst
  task automatic send_item(logic [7:0] b, g, r, logic fl);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_blue <= b; in_green <= g; in_red <= r; in_flush <= fl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (!fl) pixels_sent++;
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    in_valid <= 1'b0;
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val[sbl_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_edges != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // One frame: pixels (some flushes sprinkled in), then drain flushes
  task automatic run_frame(int w, int h, int mode);
    logic [7:0] b, g, r;
    int eff_w, eff_h;
    eff_w = (w == 0) ? 1 : (w > sbl_pkg::MAX_WIDTH_DEF ? sbl_pkg::MAX_WIDTH_DEF : w);
    eff_h = (h == 0) ? 1 : (h > sbl_pkg::MAX_HEIGHT_DEF ? sbl_pkg::MAX_HEIGHT_DEF : h);
    write_reg(sbl_pkg::CFG_FRAME_WIDTH, w);
    write_reg(sbl_pkg::CFG_FRAME_HEIGHT, h);
    for (int k = 0; k < eff_w * eff_h; k++) begin
      case (mode)
        0: begin b = 8'hFF; g = 8'h00; r = (k % 2) ? 8'hFF : 8'h00; end
        1: begin b = (k % 3 == 0) ? 8'hFF : 8'h00; g = ~b; r = 8'hFF; end
        default: begin
          b = 8'($urandom); g = 8'($urandom); r = 8'($urandom);
          if ($urandom_range(0, 3) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
      endcase
      if ($urandom_range(0, 15) == 0)
        send_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      send_item(b, g, r, 1'b0);
    end
    for (int k = 0; k < eff_w + 1; k++) begin
      // pixels during the drain are taken as zero padding, like flushes
      if ($urandom_range(0, 3) == 0)
        send_item(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      else send_item(8'h00, 8'h00, 8'h00, 1'b1);
    end
    frames_run++;
    wait_drained();
  endtask

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed: tiny frames, extremes and out-of-range registers
    run_frame(1, 1, 0);
    run_frame(0, 0, 0);
    run_frame(3, 4, 1);
    run_frame(1, 5, 0);
    run_frame(4, 1, 1);
    // Long receiver hold while the sender keeps offering
    hold_out = 1'b1;
    fork
      run_frame(8, 6, 2);
      begin
        repeat (200) @(negedge clk);
        hold_out = 1'b0;
      end
    join
    // Random frames
    while (items_sent < 1100) begin
      run_frame($urandom_range(1, 12), $urandom_range(1, 10), 2);
      if (items_sent > 950) calm = 1'b1;
    end
    calm = 1'b1;
    run_frame(7, 5, 2);
    $display("covered %0d frames, %0d items (%0d pixels), %0d edge pixels checked",
             frames_run, items_sent, pixels_sent, edge_count);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
